/* rtl/hps_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the hstore pair scanner.
// No dependencies; used by every module of the block.
package hps_pkg;

   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_GREATER = 8'h3E;

   localparam logic [1:0] STATUS_PAIR      = 2'd0;
   localparam logic [1:0] STATUS_EMPTY_KEY = 2'd1;
   localparam logic [1:0] STATUS_MALFORMED = 2'd2;

   localparam int FIELD_WIDTH = 16;

   typedef struct packed {
      logic last;
      logic is_quote;
      logic is_bslash;
      logic is_equal;
      logic is_greater;
   } byte_class_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [FIELD_WIDTH-1:0] key_offset;
      logic [FIELD_WIDTH-1:0] key_length;
      logic [FIELD_WIDTH-1:0] value_offset;
      logic [FIELD_WIDTH-1:0] value_length;
   } result_type;

endpackage

/* rtl/hstore_pair_scanner.sv */
`timescale 1ns / 1ps
// Top level of the hstore pair scanner: front classifier, queue, back scanner.
// Depends on hps_pkg, hps_front, hps_queue and hps_back.
// Throughput is one byte beat per cycle, except while a result held for rsp stalls the next last beat.
// The result passes through the front register, the queue and the back-stage output register to rsp.
// Reset is synchronous and active high; it empties the queue and output register
// and returns the scanner to its start phase with all counters cleared.
module hstore_pair_scanner #(
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // key_offset, key_length, value_offset, value_length
   output logic [1:0]  rsp_tuser    // status
);

   logic                    front_valid;
   logic                    front_ready;
   hps_pkg::byte_class_type front_class;
   logic                    queue_valid;
   logic                    queue_ready;
   hps_pkg::byte_class_type queue_class;
   hps_pkg::result_type     result;

   hps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_class (front_class)
   );

   hps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_class (front_class),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_class  (queue_class)
   );

   hps_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (queue_valid),
      .in_ready   (queue_ready),
      .in_class   (queue_class),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tuser = result.status;
   assign rsp_tdata = {result.value_length, result.value_offset,
                       result.key_length, result.key_offset};

endmodule

/* rtl/hps_front.sv */
`timescale 1ns / 1ps
// Front stage: accepts input beats and classifies each byte into flags.
// Depends on hps_pkg.
module hps_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [7:0]            in_byte,
   input  logic                  in_last,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hps_pkg::byte_class_type out_class
);

   logic                   valid_ff;
   logic                   valid_in;
   hps_pkg::byte_class_type class_ff;
   hps_pkg::byte_class_type class_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_class = class_ff;

   always_comb begin
      valid_in = valid_ff;
      class_in = class_ff;
      if (in_ready) begin
         valid_in            = in_valid;
         class_in.last       = in_last;
         class_in.is_quote   = (in_byte == hps_pkg::CHAR_QUOTE);
         class_in.is_bslash  = (in_byte == hps_pkg::CHAR_BSLASH);
         class_in.is_equal   = (in_byte == hps_pkg::CHAR_EQUAL);
         class_in.is_greater = (in_byte == hps_pkg::CHAR_GREATER);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      class_ff <= class_in;
   end

endmodule

/* rtl/hps_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue of classified bytes between the front and back stages.
// Depends on hps_pkg.
module hps_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  hps_pkg::byte_class_type push_class,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output hps_pkg::byte_class_type pop_class
);

   hps_pkg::byte_class_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_class  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_class;
      end
   end

endmodule

/* rtl/hps_back.sv */
`timescale 1ns / 1ps
// Back stage: runs the scanner state machine over classified bytes and
// holds the result in an output register. Depends on hps_pkg.
module hps_back #(
   parameter int POSITION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hps_pkg::byte_class_type in_class,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hps_pkg::result_type   out_result
);

   typedef enum logic [2:0] {
      PH_BEFORE_KEY,
      PH_IN_KEY,
      PH_AFTER_KEY,
      PH_AFTER_EQ,
      PH_BEFORE_VALUE,
      PH_IN_VALUE,
      PH_DONE,
      PH_BAD
   } phase_type;

   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

   phase_type                phase_ff, phase_in, phase_next;
   logic                     esc_ff, esc_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] key_begin_ff, key_begin_in;
   logic [POSITION_BITS-1:0] key_count_ff, key_count_in;
   logic [POSITION_BITS-1:0] value_begin_ff, value_begin_in;
   logic [POSITION_BITS-1:0] value_count_ff, value_count_in;
   logic                     valid_ff, valid_in;
   hps_pkg::result_type      result_ff, result_in;
   logic                     take;
   logic                     closes;

   assign in_ready   = !in_class.last || !valid_ff || out_ready;
   assign take       = in_valid && in_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;
   assign closes     = in_class.is_quote && !esc_ff;

   always_comb begin
      phase_next     = phase_ff;
      esc_in         = esc_ff;
      pos_in         = pos_ff;
      key_begin_in   = key_begin_ff;
      key_count_in   = key_count_ff;
      value_begin_in = value_begin_ff;
      value_count_in = value_count_ff;
      valid_in       = valid_ff && !out_ready;
      result_in      = result_ff;

      if (take) begin
         if (pos_ff == '1) begin
            phase_next = PH_BAD;
         end else begin
            pos_in = pos_ff + POS_ONE;
            case (phase_ff)
               PH_BEFORE_KEY: begin
                  if (in_class.is_quote) begin
                     phase_next   = PH_IN_KEY;
                     key_begin_in = pos_ff + POS_ONE;
                     esc_in       = 1'b0;
                  end
               end
               PH_IN_KEY: begin
                  if (closes) begin
                     phase_next = PH_AFTER_KEY;
                     esc_in     = 1'b0;
                  end else begin
                     key_count_in = key_count_ff + POS_ONE;
                     esc_in       = in_class.is_bslash;
                  end
               end
               PH_AFTER_KEY: begin
                  if (in_class.is_equal) begin
                     phase_next = PH_AFTER_EQ;
                  end
               end
               PH_AFTER_EQ: begin
                  phase_next = in_class.is_greater ? PH_BEFORE_VALUE : PH_BAD;
               end
               PH_BEFORE_VALUE: begin
                  if (in_class.is_quote) begin
                     phase_next     = PH_IN_VALUE;
                     value_begin_in = pos_ff + POS_ONE;
                     esc_in         = 1'b0;
                  end
               end
               PH_IN_VALUE: begin
                  if (closes) begin
                     phase_next = PH_DONE;
                     esc_in     = 1'b0;
                  end else begin
                     value_count_in = value_count_ff + POS_ONE;
                     esc_in         = in_class.is_bslash;
                  end
               end
               default: begin
               end
            endcase
         end

         if (in_class.last) begin
            valid_in = 1'b1;
            if (phase_next == PH_DONE) begin
               result_in.status       = (key_count_in == '0) ?
                                        hps_pkg::STATUS_EMPTY_KEY : hps_pkg::STATUS_PAIR;
               result_in.key_offset   = hps_pkg::FIELD_WIDTH'(key_begin_in);
               result_in.key_length   = hps_pkg::FIELD_WIDTH'(key_count_in);
               result_in.value_offset = hps_pkg::FIELD_WIDTH'(value_begin_in);
               result_in.value_length = hps_pkg::FIELD_WIDTH'(value_count_in);
            end else begin
               result_in.status       = hps_pkg::STATUS_MALFORMED;
               result_in.key_offset   = '0;
               result_in.key_length   = '0;
               result_in.value_offset = '0;
               result_in.value_length = '0;
            end
            phase_next     = PH_BEFORE_KEY;
            esc_in         = 1'b0;
            pos_in         = '0;
            key_begin_in   = '0;
            key_count_in   = '0;
            value_begin_in = '0;
            value_count_in = '0;
         end
      end
      phase_in = phase_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_BEFORE_KEY;
         esc_ff         <= 1'b0;
         pos_ff         <= '0;
         key_begin_ff   <= '0;
         key_count_ff   <= '0;
         value_begin_ff <= '0;
         value_count_ff <= '0;
         valid_ff       <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         esc_ff         <= esc_in;
         pos_ff         <= pos_in;
         key_begin_ff   <= key_begin_in;
         key_count_ff   <= key_count_in;
         value_begin_ff <= value_begin_in;
         value_count_ff <= value_count_in;
         valid_ff       <= valid_in;
      end
      result_ff <= result_in;
   end

endmodule

/* tb/sv/tb_hstore_pair_scanner.sv */
`timescale 1ns / 1ps
// Self-checking testbench for hstore_pair_scanner: drives text beats, predicts each
// result with its own scanner model and checks every rsp beat field by field.
// Depends on hps_pkg and the hstore_pair_scanner RTL.
module tb_hstore_pair_scanner;

   localparam int POSITION_BITS = 16;
   localparam logic [POSITION_BITS-1:0] POSITION_LIMIT = '1;

   typedef enum logic [2:0] {
      SCAN_BEFORE_KEY,
      SCAN_IN_KEY,
      SCAN_AFTER_KEY,
      SCAN_AFTER_EQUAL,
      SCAN_BEFORE_VALUE,
      SCAN_IN_VALUE,
      SCAN_DONE,
      SCAN_BAD
   } scan_phase_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   scan_phase_type           scan_phase;
   bit                       esc_pending;
   logic [POSITION_BITS-1:0] next_pos;
   logic [POSITION_BITS-1:0] key_origin;
   logic [POSITION_BITS-1:0] key_bytes;
   logic [POSITION_BITS-1:0] value_origin;
   logic [POSITION_BITS-1:0] value_bytes;

   hps_pkg::result_type pending_results[$];
   logic [7:0]          text_bytes[$];
   int                  error_count = 0;
   bit                  sender_gaps = 0;
   bit                  receiver_gaps = 0;
   int                  hold_cycles = 0;

   hstore_pair_scanner #(
      .POSITION_BITS(POSITION_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic void clear_scan();
      scan_phase   = SCAN_BEFORE_KEY;
      esc_pending  = 1'b0;
      next_pos     = '0;
      key_origin   = '0;
      key_bytes    = '0;
      value_origin = '0;
      value_bytes  = '0;
   endfunction

   function automatic void count_string_byte(input bit in_value);
      if (in_value) begin
         value_bytes = value_bytes + POSITION_BITS'(1);
      end else begin
         key_bytes = key_bytes + POSITION_BITS'(1);
      end
   endfunction

   // Returns 1 when the byte closes the quoted string.
   function automatic bit string_closes(input logic [7:0] b, input bit in_value);
      if (esc_pending) begin
         esc_pending = 1'b0;
         if (b == hps_pkg::CHAR_QUOTE) begin
            count_string_byte(in_value);
            return 1'b0;
         end
      end
      if (b == hps_pkg::CHAR_QUOTE) begin
         return 1'b1;
      end
      count_string_byte(in_value);
      if (b == hps_pkg::CHAR_BSLASH) begin
         esc_pending = 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void track_byte(input logic [7:0] b, input bit is_last);
      logic [POSITION_BITS-1:0] pos;
      hps_pkg::result_type      r;
      pos = next_pos;
      if (pos >= POSITION_LIMIT) begin
         scan_phase = SCAN_BAD;
      end else begin
         next_pos = pos + POSITION_BITS'(1);
         case (scan_phase)
            SCAN_BEFORE_KEY: begin
               if (b == hps_pkg::CHAR_QUOTE) begin
                  scan_phase  = SCAN_IN_KEY;
                  key_origin  = pos + POSITION_BITS'(1);
                  esc_pending = 1'b0;
               end
            end
            SCAN_IN_KEY: begin
               if (string_closes(b, 1'b0)) begin
                  scan_phase  = SCAN_AFTER_KEY;
                  esc_pending = 1'b0;
               end
            end
            SCAN_AFTER_KEY: begin
               if (b == hps_pkg::CHAR_EQUAL) begin
                  scan_phase = SCAN_AFTER_EQUAL;
               end
            end
            SCAN_AFTER_EQUAL: begin
               scan_phase = (b == hps_pkg::CHAR_GREATER) ? SCAN_BEFORE_VALUE : SCAN_BAD;
            end
            SCAN_BEFORE_VALUE: begin
               if (b == hps_pkg::CHAR_QUOTE) begin
                  scan_phase   = SCAN_IN_VALUE;
                  value_origin = pos + POSITION_BITS'(1);
                  esc_pending  = 1'b0;
               end
            end
            SCAN_IN_VALUE: begin
               if (string_closes(b, 1'b1)) begin
                  scan_phase  = SCAN_DONE;
                  esc_pending = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
      if (is_last) begin
         r = '0;
         if (scan_phase == SCAN_DONE) begin
            r.status       = (key_bytes == '0) ? hps_pkg::STATUS_EMPTY_KEY :
                                                 hps_pkg::STATUS_PAIR;
            r.key_offset   = key_origin;
            r.key_length   = key_bytes;
            r.value_offset = value_origin;
            r.value_length = value_bytes;
         end else begin
            r.status = hps_pkg::STATUS_MALFORMED;
         end
         pending_results.push_back(r);
         clear_scan();
      end
   endfunction

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_result(input logic [63:0] data, input logic [1:0] user);
      hps_pkg::result_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result beat, expected none, actual status %0d data %h",
                  $time, user, data);
         error_count++;
      end else begin
         want = pending_results.pop_front();
         compare_field("status", 16'(want.status), 16'(user));
         compare_field("key_offset", want.key_offset, data[15:0]);
         compare_field("key_length", want.key_length, data[31:16]);
         compare_field("value_offset", want.value_offset, data[47:32]);
         compare_field("value_length", want.value_length, data[63:48]);
      end
   endtask

   initial begin : result_sink
      int gap;
      gap = 0;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         gap = 0;
         rsp_tready <= 1'b1;
         @(posedge clock);
         if (rsp_tvalid) begin
            check_result(rsp_tdata, rsp_tuser);
            gap = receiver_gaps ? $urandom_range(0, 15) : 0;
         end
      end
   end

   task automatic send_beat(input logic [7:0] b, input bit is_last);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      track_byte(b, is_last);
   endtask

   task automatic send_chars(input string s, input bit ends_item);
      for (int i = 0; i < s.len(); i++) begin
         send_beat(s[i], ends_item && (i == s.len() - 1));
      end
   endtask

   task automatic send_text_bytes();
      for (int i = 0; i < text_bytes.size(); i++) begin
         send_beat(text_bytes[i], i == text_bytes.size() - 1);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   function automatic logic [7:0] byte_except(input logic [7:0] avoid);
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == avoid);
      return b;
   endfunction

   function automatic logic [7:0] marker_heavy_byte();
      case ($urandom_range(0, 7))
         0: return hps_pkg::CHAR_QUOTE;
         1: return hps_pkg::CHAR_BSLASH;
         2: return hps_pkg::CHAR_EQUAL;
         3: return hps_pkg::CHAR_GREATER;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void add_string_body(input int count);
      repeat (count) begin
         case ($urandom_range(0, 9))
            0: begin
               text_bytes.push_back(hps_pkg::CHAR_BSLASH);
               text_bytes.push_back(hps_pkg::CHAR_QUOTE);
            end
            1: begin
               text_bytes.push_back(hps_pkg::CHAR_BSLASH);
               text_bytes.push_back(byte_except(hps_pkg::CHAR_QUOTE));
            end
            2: text_bytes.push_back(byte_except(hps_pkg::CHAR_QUOTE));
            default: text_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
         endcase
      end
   endfunction

   function automatic void build_pair();
      text_bytes.delete();
      repeat ($urandom_range(0, 2)) text_bytes.push_back(byte_except(hps_pkg::CHAR_QUOTE));
      text_bytes.push_back(hps_pkg::CHAR_QUOTE);
      add_string_body(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8));
      text_bytes.push_back(hps_pkg::CHAR_QUOTE);
      repeat ($urandom_range(0, 2)) text_bytes.push_back(byte_except(hps_pkg::CHAR_EQUAL));
      text_bytes.push_back(hps_pkg::CHAR_EQUAL);
      text_bytes.push_back(hps_pkg::CHAR_GREATER);
      repeat ($urandom_range(0, 2)) text_bytes.push_back(byte_except(hps_pkg::CHAR_QUOTE));
      text_bytes.push_back(hps_pkg::CHAR_QUOTE);
      add_string_body($urandom_range(0, 8));
      text_bytes.push_back(hps_pkg::CHAR_QUOTE);
      repeat ($urandom_range(0, 2)) text_bytes.push_back(marker_heavy_byte());
   endfunction

   task automatic test_directed();
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      send_chars("\"key\"=>\"value\"", 1'b1);
      send_chars("\"\"=>\"v\"", 1'b1);
      send_chars("\"\"=>\"\"", 1'b1);
      send_chars("\"k\"=x\"v\"", 1'b1);
      send_chars("\"k\"==>\"v\"", 1'b1);
      send_chars("ab\"k\\\"q\" x=>  \"v\\w\\\"\" tail", 1'b1);
      send_chars("\"=\"=>\">\"", 1'b1);
      send_chars("\"k\"=>\"v", 1'b1);
      send_chars("\"k\\", 1'b1);
      send_chars("\"a\\\\\"=>\"b\"", 1'b1);
      send_beat(8'h00, 1'b1);
      send_beat(8'hFF, 1'b1);
      send_chars("\"k\"=>\"v\"", 1'b0);
      send_beat(8'hFF, 1'b1);
      drain_results();
   endtask

   task automatic test_output_stall();
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      hold_cycles   = 400;
      repeat (40) send_chars("\"ab\"=>\"cd\"", 1'b1);
      drain_results();
   endtask

   task automatic test_random_items();
      int beats;
      int texts;
      int kind;
      int cut;
      beats = 0;
      texts = 0;
      while (beats < 840 || texts < 48) begin
         if (texts % 16 == 0) begin
            receiver_gaps = 1'($urandom_range(0, 1));
         end
         sender_gaps = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 9);
         if (kind == 9) begin
            text_bytes.delete();
            repeat ($urandom_range(1, 12)) text_bytes.push_back(marker_heavy_byte());
         end else begin
            build_pair();
            if (kind == 8) begin
               cut = $urandom_range(1, text_bytes.size());
               if ($urandom_range(0, 1) == 0) begin
                  while (text_bytes.size() > cut) void'(text_bytes.pop_back());
               end else begin
                  text_bytes[cut - 1] = marker_heavy_byte();
               end
            end
         end
         send_text_bytes();
         beats += text_bytes.size();
         texts++;
         if ($urandom_range(0, 24) == 0) begin
            drain_results();
         end
      end
      drain_results();
   endtask

   initial begin : stimulus
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tlast  <= 1'b0;
      reset      <= 1'b1;
      clear_scan();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_output_stall();
      test_random_items();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
